// ----- design/tces_pkg.sv -----
// ----------------------------------------------------------------------------
// tces_pkg
// Shared sizes, codes and types of the timed cue event scheduler.
// ----------------------------------------------------------------------------
package tces_pkg;

    localparam int CUE_SLOTS = 32;
    localparam int TIME_BITS = 40;

    // Slot index and fill count widths.
    localparam int SLOT_W  = (CUE_SLOTS > 1) ? $clog2(CUE_SLOTS) : 1;
    localparam int COUNT_W = $clog2(CUE_SLOTS + 1);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TIME_BITS:0]   stamp_t;
    typedef logic [31:0]          handle_t;

    // Operation codes of an input word.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_REARM  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Reply kinds of an output word.
    localparam logic [2:0] RK_STARTED = 3'd0;
    localparam logic [2:0] RK_ENDED   = 3'd1;
    localparam logic [2:0] RK_ADD     = 3'd2;
    localparam logic [2:0] RK_REMOVE  = 3'd3;
    localparam logic [2:0] RK_DONE    = 3'd4;

    // One stored cue.
    typedef struct packed {
        handle_t handle;
        time_t   start;
        time_t   length;
    } entry_t;

endpackage

// ----- design/timed_cue_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// timed_cue_event_scheduler
// Table of timed cues that fires start and end events in time order.
// ----------------------------------------------------------------------------
// Input words (s_ channel) carry an operation: tick, add, remove, rearm or
// clear. Each word yields one or more output words (m_ channel); the final
// word of a run has m_last_of_run set. The block takes one input word at a
// time and raises s_ready again only after its last output word is loaded.
// Add, rearm, clear, an unknown code and a backward tick go from acceptance
// to a reply state that loads the reply once the output register is free,
// then take the next word. Remove walks the table on the single memory read
// port, moving each cue whose handle differs from the target down to close
// the gap. A tick runs one scan pass per fired event plus a closing pass; a
// pass checks each cue's start and end on one shared compare unit.
// Reset empties the table, sets the handle counter to one and marks the
// previous time unknown; the cue memory itself is not cleared.
// When the receiver stalls, the output register holds its word and the
// sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module timed_cue_event_scheduler
    import tces_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [39:0] s_time_value,
    input  logic [39:0] s_cue_length,
    input  logic [31:0] s_target_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reply_kind,
    output logic [31:0] m_cue_handle,
    output logic [40:0] m_event_stamp,
    output logic        m_success,
    output logic        m_last_of_run
);

    typedef enum logic [3:0] {
        S_IDLE, S_REPLY, S_SCAN_RD, S_SCAN_S, S_SCAN_E, S_SCAN_END,
        S_HREAD, S_HCAP, S_RM_RD, S_RM_WR
    } state_t;

    state_t                 state_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     idx_reg;
    logic [COUNT_W-1:0]     wr_idx_reg;
    logic [CUE_SLOTS-1:0]   started_reg;
    logic [CUE_SLOTS-1:0]   ended_reg;
    handle_t                counter_reg;
    time_t                  prev_reg;
    logic                   known_reg;
    time_t                  now_reg;
    handle_t                target_reg;
    logic                   found_reg;
    logic                   best_found_reg;
    stamp_t                 best_stamp_reg;
    logic                   best_phase_reg;
    logic [SLOT_W-1:0]      best_slot_reg;
    logic                   pend_valid_reg;
    stamp_t                 pend_stamp_reg;
    logic                   pend_phase_reg;
    handle_t                pend_handle_reg;
    logic [2:0]             rep_kind_reg;
    handle_t                rep_handle_reg;
    logic                   rep_ok_reg;
    logic                   m_valid_reg;
    logic [2:0]             m_kind_reg;
    handle_t                m_handle_reg;
    logic [40:0]            m_stamp_reg;
    logic                   m_ok_reg;
    logic                   m_last_reg;

    // Cue memory with one write port and one registered read port.
    entry_t                 mem [CUE_SLOTS];
    entry_t                 rd_data_reg;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_wa;
    entry_t                 mem_wd;

    time_t                  in_time;
    time_t                  in_len;
    logic                   out_free;
    logic                   out_load;
    logic [SLOT_W-1:0]      idx_slot;
    logic [SLOT_W-1:0]      wr_slot;
    logic                   table_full;

    // Shared event compare unit.
    logic                   end_phase;
    stamp_t                 cand_stamp;
    logic                   cand_ok;
    logic                   in_win;
    logic                   better;
    logic                   rm_hit;

    assign in_time    = time_t'(s_time_value);
    assign in_len     = time_t'(s_cue_length);
    assign out_free   = !m_valid_reg || m_ready;
    assign idx_slot   = idx_reg[SLOT_W-1:0];
    assign wr_slot    = wr_idx_reg[SLOT_W-1:0];
    assign table_full = (count_reg == COUNT_W'(CUE_SLOTS));
    assign s_ready    = (state_reg == S_IDLE);

    // The sequencer loads a new output word in this cycle.
    assign out_load = out_free && ((state_reg == S_REPLY) ||
                      ((state_reg == S_SCAN_END) && !(best_found_reg && !pend_valid_reg)));

    assign rd_addr = (state_reg == S_HREAD || state_reg == S_HCAP) ? best_slot_reg
                                                                   : idx_slot;

    // Candidate is the start in one cycle and the end in the next.
    assign end_phase  = (state_reg == S_SCAN_E);
    assign cand_stamp = end_phase ? ({1'b0, rd_data_reg.start} + {1'b0, rd_data_reg.length})
                                  : {1'b0, rd_data_reg.start};
    assign cand_ok    = end_phase ? ((rd_data_reg.length != '0) && !ended_reg[idx_slot])
                                  : !started_reg[idx_slot];
    assign in_win     = (cand_stamp <= {1'b0, now_reg}) &&
                        (!known_reg || (cand_stamp > {1'b0, prev_reg}));
    assign better     = !best_found_reg || (cand_stamp < best_stamp_reg) ||
                        ((cand_stamp == best_stamp_reg) && !end_phase && best_phase_reg);

    assign rm_hit = (rd_data_reg.handle == target_reg);

    // Memory write port select.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = count_reg[SLOT_W-1:0];
        mem_wd = '{handle: counter_reg, start: in_time, length: in_len};
        if (state_reg == S_IDLE) begin
            mem_we = s_valid && (s_operation == OP_ADD) && !table_full;
        end else if (state_reg == S_RM_WR) begin
            mem_we = !rm_hit && (wr_idx_reg != idx_reg);
            mem_wa = wr_slot;
            mem_wd = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            started_reg    <= '0;
            ended_reg      <= '0;
            counter_reg    <= 32'd1;
            prev_reg       <= '0;
            known_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        now_reg      <= in_time;
                        target_reg   <= s_target_handle;
                        rep_kind_reg <= RK_DONE;
                        rep_handle_reg <= '0;
                        rep_ok_reg   <= 1'b0;
                        idx_reg      <= '0;
                        wr_idx_reg   <= '0;
                        found_reg    <= 1'b0;
                        best_found_reg <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        state_reg    <= S_REPLY;
                        case (s_operation)
                            OP_TICK: begin
                                if (known_reg && (in_time < prev_reg)) begin
                                    prev_reg <= in_time;
                                end else begin
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            OP_ADD: begin
                                rep_kind_reg <= RK_ADD;
                                if (!table_full) begin
                                    started_reg[count_reg[SLOT_W-1:0]] <= 1'b0;
                                    ended_reg[count_reg[SLOT_W-1:0]]   <= 1'b0;
                                    count_reg      <= count_reg + COUNT_W'(1);
                                    rep_handle_reg <= counter_reg;
                                    rep_ok_reg     <= 1'b1;
                                    counter_reg    <= (counter_reg == 32'hFFFF_FFFF) ? 32'd1
                                                      : counter_reg + 32'd1;
                                end
                            end
                            OP_REMOVE: begin
                                state_reg <= S_RM_RD;
                            end
                            OP_REARM: begin
                                started_reg <= '0;
                                ended_reg   <= '0;
                                prev_reg    <= '0;
                                known_reg   <= 1'b0;
                            end
                            OP_CLEAR: begin
                                count_reg   <= '0;
                                started_reg <= '0;
                                ended_reg   <= '0;
                                prev_reg    <= '0;
                                known_reg   <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_REPLY: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_kind_reg   <= rep_kind_reg;
                        m_handle_reg <= rep_handle_reg;
                        m_stamp_reg  <= '0;
                        m_ok_reg     <= rep_ok_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= (idx_reg == count_reg) ? S_SCAN_END : S_SCAN_S;
                end
                S_SCAN_S, S_SCAN_E: begin
                    if (cand_ok && in_win && better) begin
                        best_found_reg <= 1'b1;
                        best_stamp_reg <= cand_stamp;
                        best_phase_reg <= end_phase;
                        best_slot_reg  <= idx_slot;
                    end
                    if (end_phase) begin
                        idx_reg   <= idx_reg + COUNT_W'(1);
                        state_reg <= S_SCAN_RD;
                    end else begin
                        state_reg <= S_SCAN_E;
                    end
                end
                S_SCAN_END: begin
                    if (best_found_reg && !pend_valid_reg) begin
                        state_reg <= S_HREAD;
                    end else if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_ok_reg    <= 1'b0;
                        m_last_reg  <= !best_found_reg;
                        if (pend_valid_reg) begin
                            m_kind_reg   <= pend_phase_reg ? RK_ENDED : RK_STARTED;
                            m_handle_reg <= pend_handle_reg;
                            m_stamp_reg  <= 41'(pend_stamp_reg);
                        end else begin
                            m_kind_reg   <= RK_DONE;
                            m_handle_reg <= '0;
                            m_stamp_reg  <= '0;
                        end
                        if (best_found_reg) begin
                            state_reg <= S_HREAD;
                        end else begin
                            pend_valid_reg <= 1'b0;
                            prev_reg       <= now_reg;
                            known_reg      <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_HREAD: begin
                    if (best_phase_reg) begin
                        ended_reg[best_slot_reg] <= 1'b1;
                    end else begin
                        started_reg[best_slot_reg] <= 1'b1;
                    end
                    state_reg <= S_HCAP;
                end
                S_HCAP: begin
                    pend_valid_reg  <= 1'b1;
                    pend_handle_reg <= rd_data_reg.handle;
                    pend_stamp_reg  <= best_stamp_reg;
                    pend_phase_reg  <= best_phase_reg;
                    best_found_reg  <= 1'b0;
                    idx_reg         <= '0;
                    state_reg       <= S_SCAN_RD;
                end
                S_RM_RD: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= wr_idx_reg;
                        for (int k = 0; k < CUE_SLOTS; k++) begin
                            if (COUNT_W'(k) >= wr_idx_reg) begin
                                started_reg[k] <= 1'b0;
                                ended_reg[k]   <= 1'b0;
                            end
                        end
                        rep_kind_reg <= RK_REMOVE;
                        rep_ok_reg   <= found_reg;
                        state_reg    <= S_REPLY;
                    end else begin
                        state_reg <= S_RM_WR;
                    end
                end
                S_RM_WR: begin
                    if (rm_hit) begin
                        found_reg <= 1'b1;
                    end else begin
                        started_reg[wr_slot] <= started_reg[idx_slot];
                        ended_reg[wr_slot]   <= ended_reg[idx_slot];
                        wr_idx_reg           <= wr_idx_reg + COUNT_W'(1);
                    end
                    idx_reg   <= idx_reg + COUNT_W'(1);
                    state_reg <= S_RM_RD;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_kind  = m_kind_reg;
    assign m_cue_handle  = m_handle_reg;
    assign m_event_stamp = m_stamp_reg;
    assign m_success     = m_ok_reg;
    assign m_last_of_run = m_last_reg;

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CUE_SLOTS))
        else $error("fill count above table size");

    // The handle counter never hands out handle zero.
    a_counter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        counter_reg != '0)
        else $error("handle counter reached zero");

    // A held event never survives into idle.
    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_valid_reg && state_reg == S_IDLE))
        else $error("pending event left behind");

    // A scan never reads past the fill count.
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_S || state_reg == S_SCAN_E) |-> idx_reg < count_reg)
        else $error("scan index beyond fill count");

endmodule

// ----- tb/timed_cue_event_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// timed_cue_event_scheduler_tb
// Self-checking bench for the timed cue event scheduler. A directed table
// covers extremes, every operation, ties, backward and silent ticks and
// unknown codes. A table overfill and random cue sequences follow. Every
// output word is compared against a cue table model kept inside the bench.
// ----------------------------------------------------------------------------
module timed_cue_event_scheduler_tb
    import tces_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [39:0] s_time_value;
    logic [39:0] s_cue_length;
    logic [31:0] s_target_handle;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_reply_kind;
    logic [31:0] m_cue_handle;
    logic [40:0] m_event_stamp;
    logic        m_success;
    logic        m_last_of_run;

    // One output word.
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] handle;
        logic [40:0] stamp;
        logic        ok;
        logic        last;
    } reply_t;

    // One input word; chk marks rows with a typed-in final reply.
    typedef struct {
        logic [2:0]  op;
        logic [39:0] tv;
        logic [39:0] len;
        logic [31:0] tgt;
        bit          chk;
        reply_t      want;
    } cmd_t;

    // Typed-in reply and the number of the input word it belongs to.
    typedef struct {
        int     seq;
        reply_t want;
    } typed_t;

    // Bench copy of the cue table.
    logic    tbl_used [CUE_SLOTS];
    handle_t tbl_handle [CUE_SLOTS];
    time_t   tbl_start [CUE_SLOTS];
    time_t   tbl_len [CUE_SLOTS];
    logic    tbl_started [CUE_SLOTS];
    logic    tbl_ended [CUE_SLOTS];
    handle_t next_handle;
    time_t   prev_time;
    logic    prev_known;

    reply_t  pending_replies[$];
    typed_t  typed_replies[$];
    cmd_t    dir_rows[$];
    int      errors;
    int      words_sent;
    int      words_done;
    bit      hold_off;
    bit      feeding_done;

    timed_cue_event_scheduler dut (.*);

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous overall limit.
    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic reply_t mk(logic [2:0] k, logic [31:0] h, logic [40:0] s,
                                  logic o, logic l);
        reply_t r;
        r.kind = k; r.handle = h; r.stamp = s; r.ok = o; r.last = l;
        return r;
    endfunction

    function automatic bit in_span(logic [40:0] t, time_t now);
        if (t > {1'b0, now}) return 0;
        if (prev_known && t <= {1'b0, prev_time}) return 0;
        return 1;
    endfunction

    // Applies one input word to the cue table and queues its replies.
    function automatic void schedule_word(cmd_t c);
        reply_t      evs[$];
        int          slot_of[$];
        int          w;
        bit          found;
        bit          placed;
        logic [40:0] fin;
        reply_t      key;
        int          ks;
        int          j;
        case (c.op)
            OP_TICK: begin
                if (prev_known && c.tv < prev_time) begin
                    prev_time = c.tv;
                end else begin
                    for (int i = 0; i < CUE_SLOTS; i++) begin
                        if (!tbl_used[i]) continue;
                        if (!tbl_started[i] && in_span({1'b0, tbl_start[i]}, c.tv)) begin
                            tbl_started[i] = 1;
                            evs.insert(evs.size(), mk(RK_STARTED, tbl_handle[i],
                                                      {1'b0, tbl_start[i]}, 0, 0));
                            slot_of.insert(slot_of.size(), i);
                        end
                        fin = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
                        if (tbl_len[i] != 0 && !tbl_ended[i] && in_span(fin, c.tv)) begin
                            tbl_ended[i] = 1;
                            evs.insert(evs.size(), mk(RK_ENDED, tbl_handle[i], fin, 0, 0));
                            slot_of.insert(slot_of.size(), i);
                        end
                    end
                    // Insertion sort by time, then phase, then slot.
                    for (int i = 1; i < evs.size(); i++) begin
                        key = evs[i]; ks = slot_of[i]; j = i - 1;
                        while (j >= 0 && (key.stamp < evs[j].stamp ||
                               (key.stamp == evs[j].stamp && (key.kind < evs[j].kind ||
                               (key.kind == evs[j].kind && ks < slot_of[j]))))) begin
                            evs[j + 1] = evs[j]; slot_of[j + 1] = slot_of[j]; j--;
                        end
                        evs[j + 1] = key; slot_of[j + 1] = ks;
                    end
                    prev_time = c.tv;
                    prev_known = 1;
                end
                if (evs.size() == 0) begin
                    pending_replies.insert(pending_replies.size(), mk(RK_DONE, 0, 0, 0, 1));
                end else begin
                    evs[evs.size() - 1].last = 1;
                    foreach (evs[i]) pending_replies.insert(pending_replies.size(), evs[i]);
                end
            end
            OP_ADD: begin
                placed = 0;
                for (int i = 0; i < CUE_SLOTS && !placed; i++) begin
                    if (!tbl_used[i]) begin
                        tbl_used[i] = 1; tbl_handle[i] = next_handle;
                        tbl_start[i] = c.tv; tbl_len[i] = c.len;
                        tbl_started[i] = 0; tbl_ended[i] = 0;
                        pending_replies.insert(pending_replies.size(),
                                               mk(RK_ADD, next_handle, 0, 1, 1));
                        next_handle = next_handle + 32'd1;
                        if (next_handle == 0) next_handle = 1;
                        placed = 1;
                    end
                end
                if (!placed)
                    pending_replies.insert(pending_replies.size(), mk(RK_ADD, 0, 0, 0, 1));
            end
            OP_REMOVE: begin
                w = 0; found = 0;
                for (int i = 0; i < CUE_SLOTS; i++) begin
                    if (!tbl_used[i]) continue;
                    if (tbl_handle[i] == c.tgt) begin
                        found = 1;
                        continue;
                    end
                    tbl_used[w] = 1; tbl_handle[w] = tbl_handle[i];
                    tbl_start[w] = tbl_start[i]; tbl_len[w] = tbl_len[i];
                    tbl_started[w] = tbl_started[i]; tbl_ended[w] = tbl_ended[i];
                    w++;
                end
                for (int i = w; i < CUE_SLOTS; i++) begin
                    tbl_used[i] = 0; tbl_started[i] = 0; tbl_ended[i] = 0;
                end
                pending_replies.insert(pending_replies.size(), mk(RK_REMOVE, 0, 0, found, 1));
            end
            default: begin
                if (c.op == OP_REARM || c.op == OP_CLEAR) begin
                    for (int i = 0; i < CUE_SLOTS; i++) begin
                        tbl_started[i] = 0; tbl_ended[i] = 0;
                        if (c.op == OP_CLEAR) tbl_used[i] = 0;
                    end
                    prev_time = 0;
                    prev_known = 0;
                end
                pending_replies.insert(pending_replies.size(), mk(RK_DONE, 0, 0, 0, 1));
            end
        endcase
    endfunction

    function automatic int used_count();
        int n;
        n = 0;
        for (int i = 0; i < CUE_SLOTS; i++) n += tbl_used[i];
        return n;
    endfunction

    function automatic cmd_t row(logic [2:0] op, logic [39:0] tv, logic [39:0] len,
                                 logic [31:0] tgt);
        cmd_t c;
        c.op = op; c.tv = tv; c.len = len; c.tgt = tgt; c.chk = 0;
        c.want = mk(0, 0, 0, 0, 0);
        return c;
    endfunction

    function automatic cmd_t row_want(logic [2:0] op, logic [39:0] tv, logic [39:0] len,
                                      logic [31:0] tgt, reply_t want);
        cmd_t c;
        c = row(op, tv, len, tgt);
        c.chk = 1; c.want = want;
        return c;
    endfunction

    // Compares the output word on the ports with an expected one.
    task automatic check_word(reply_t e);
        if (m_reply_kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, m_reply_kind);
            errors++;
        end
        if (m_cue_handle !== e.handle) begin
            $display("%0t: handle expected %0d actual %0d", $time, e.handle,
                     m_cue_handle);
            errors++;
        end
        if (m_event_stamp !== e.stamp) begin
            $display("%0t: stamp expected %0d actual %0d", $time, e.stamp,
                     m_event_stamp);
            errors++;
        end
        if (m_success !== e.ok) begin
            $display("%0t: success expected %0b actual %0b", $time, e.ok, m_success);
            errors++;
        end
        if (m_last_of_run !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, m_last_of_run);
            errors++;
        end
    endtask

    // Sends one word and waits for its acceptance.
    task automatic send_word(cmd_t c);
        typed_t t;
        s_valid <= 1'b1;
        s_operation <= c.op;
        s_time_value <= c.tv;
        s_cue_length <= c.len;
        s_target_handle <= c.tgt;
        do @(posedge aclk); while (!s_ready);
        schedule_word(c);
        if (c.chk) begin
            t.seq = words_sent;
            t.want = c.want;
            typed_replies.insert(typed_replies.size(), t);
        end
        words_sent++;
    endtask

    // Random gap before the next word, mostly none or short.
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [39:0] rnd40();
        return {8'($urandom_range(0, 255)), $urandom()};
    endfunction

    function automatic logic [31:0] known_handle();
        int n;
        n = used_count();
        if (n == 0 || $urandom_range(0, 4) == 0) return $urandom();
        return tbl_handle[$urandom_range(0, n - 1)];
    endfunction

    // Stimulus.
    initial begin
        cmd_t        c;
        logic [39:0] base;
        int          pick;
        errors = 0;
        words_sent = 0;
        words_done = 0;
        hold_off = 0;
        feeding_done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_TICK;
        s_time_value = '0;
        s_cue_length = '0;
        s_target_handle = '0;
        for (int i = 0; i < CUE_SLOTS; i++) begin
            tbl_used[i] = 0; tbl_started[i] = 0; tbl_ended[i] = 0;
            tbl_handle[i] = 0; tbl_start[i] = 0; tbl_len[i] = 0;
        end
        next_handle = 1;
        prev_time = 0;
        prev_known = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows.
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_TICK, 0, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_REMOVE, 0, 0, 0, mk(RK_REMOVE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_ADD, 40'd10, 40'd5, 0, mk(RK_ADD, 1, 0, 1, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_ADD, 40'd15, 40'd0, 0, mk(RK_ADD, 2, 0, 1, 1)));
        dir_rows.insert(dir_rows.size(), row(OP_ADD, 40'd10, 40'd3, 0));
        dir_rows.insert(dir_rows.size(),
                        row(OP_ADD, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 0));
        dir_rows.insert(dir_rows.size(), row(OP_TICK, 40'd12, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_TICK, 40'd15, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_TICK, 40'd4, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(), row(OP_TICK, 40'd20, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_TICK, 40'd20, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(), row(OP_TICK, 40'hFF_FFFF_FFFF, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_REARM, 0, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(), row(OP_TICK, 40'hFF_FFFF_FFFF, 0, 0));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_REMOVE, 0, 0, 32'd2, mk(RK_REMOVE, 0, 0, 1, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_REMOVE, 0, 0, 32'hFFFF_FFFF,
                                 mk(RK_REMOVE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(3'd5, 40'd7, 40'd7, 32'd7, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(3'd6, 0, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(3'd7, 0, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_CLEAR, 0, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        dir_rows.insert(dir_rows.size(),
                        row_want(OP_TICK, 40'd100, 0, 0, mk(RK_DONE, 0, 0, 0, 1)));
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i]);
            sender_gap();
        end

        // Fill the table past full while the receiver holds off.
        hold_off = 1;
        for (int i = 0; i < CUE_SLOTS + 2; i++) begin
            send_word(row(OP_ADD, 40'(1000 + i), 40'((i % 3) * 7), 0));
        end
        send_word(row(OP_TICK, 40'd1100, 0, 0));
        hold_off = 0;
        send_word(row(OP_CLEAR, 0, 0, 0));

        // Random cue sequences: adds, ticks, removes, rearms, clears and unknown codes.
        base = 0;
        for (int n = 0; n < 64; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 && used_count() < CUE_SLOTS) begin
                c = row(OP_ADD, 40'(base + $urandom_range(0, 60)),
                        ($urandom_range(0, 3) == 0) ? 40'd0 : 40'($urandom_range(1, 40)),
                        $urandom());
                if ($urandom_range(0, 19) == 0) c.tv = rnd40();
                if ($urandom_range(0, 19) == 0) c.len = rnd40();
            end else if (pick < 75) begin
                base = 40'(base + $urandom_range(0, 25));
                c = row(OP_TICK, base, rnd40(), $urandom());
                if ($urandom_range(0, 15) == 0) c.tv = 40'(base - $urandom_range(1, 30));
                if ($urandom_range(0, 30) == 0) c.tv = rnd40();
            end else if (pick < 87) begin
                c = row(OP_REMOVE, rnd40(), rnd40(), known_handle());
            end else if (pick < 93) begin
                c = row(OP_REARM, rnd40(), rnd40(), $urandom());
            end else if (pick < 97) begin
                c = row(OP_CLEAR, rnd40(), rnd40(), $urandom());
                base = 0;
            end else begin
                c = row(3'($urandom_range(5, 7)), rnd40(), rnd40(), $urandom());
            end
            send_word(c);
            sender_gap();
        end
        s_valid <= 1'b0;
        feeding_done = 1;
    end

    // Receiver: random stalls, plus one long hold-off while the table fills.
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                while (hold_off) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end
            end
            g = ($urandom_range(0, 9) < 6) ? 0 :
                ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare each accepted output word with the oldest expectation, and the
    // final word of a directed row also with its typed-in reply.
    always @(posedge aclk) begin
        reply_t e;
        typed_t t;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected word kind=%0d handle=%0d", $time,
                         m_reply_kind, m_cue_handle);
                errors++;
            end else begin
                e = pending_replies.pop_front();
                check_word(e);
                if (e.last) begin
                    if (typed_replies.size() != 0 && typed_replies[0].seq == words_done) begin
                        t = typed_replies.pop_front();
                        check_word(t.want);
                    end
                    words_done++;
                end
            end
        end
    end

    // End of run.
    initial begin
        @(posedge aclk);
        wait (feeding_done);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0 && typed_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
